// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ===== hw/rtl/amcd_pkg.sv =====
package amcd_pkg;

   // parser phase, one-hot
   typedef enum logic [3:0] {
      PH_HEADER  = 4'b0001,
      PH_PAYLOAD = 4'b0010,
      PH_SKIP    = 4'b0100,
      PH_HALT    = 4'b1000
   } phase_type;

   // result kinds
   localparam logic [1:0] KIND_VIDEO    = 2'd0;
   localparam logic [1:0] KIND_AUDIO    = 2'd1;
   localparam logic [1:0] KIND_OVERSIZE = 2'd2;
   localparam logic [1:0] KIND_NO_SINK  = 2'd3;

   // input actions
   localparam logic ACT_BYTE    = 1'b0;
   localparam logic ACT_RESTART = 1'b1;

   // csr indexes
   localparam logic [1:0] CSR_VIDEO_LIMIT   = 2'd0;
   localparam logic [1:0] CSR_AUDIO_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_VIDEO_PRESENT = 2'd2;
   localparam logic [1:0] CSR_AUDIO_PRESENT = 2'd3;

   // FourCC values as gathered, first stream byte in bits 7:0
   localparam logic [31:0] TAG_00DB = 32'h6264_3030;
   localparam logic [31:0] TAG_00DC = 32'h6364_3030;
   localparam logic [31:0] TAG_01WB = 32'h6277_3130;

   // header is 8 bytes: 4 tag, 4 size
   localparam logic [2:0] HDR_LAST_POS = 3'd7;

   typedef struct packed {
      logic [1:0]  kind;
      logic        has_byte;
      logic [7:0]  payload_byte;
      logic [31:0] chunk_length;
      logic [31:0] frame_index;
      logic        last;
   } result_type;

endpackage

// ===== hw/rtl/avi_movi_chunk_demux_top.sv =====
// AVI movi chunk demultiplexer.
// req_ channel: one item per movi byte (req_action = byte) or a restart
//   (req_action = restart) that loads the video frame counter from
//   req_counter_load and drops any header or chunk in progress.
// rsp_ channel: at most one item per request; video/audio payload bytes,
//   a zero-size chunk marker, an oversize-skip notice or a missing-sink error.
// csr_ channel: register writes, always ready; write only while idle.
// A result is registered into the output queue when its request is accepted.
// Throughput: one request per cycle unless both output slots are full; all
//   parsing is a single compare, count and shift step on the parser registers.
// A two-entry output queue (result register plus skid slot) decouples the
//   sides: requests keep flowing while one result waits; req_ready drops
//   only when both slots hold results.
// After a missing-sink error the parser halts and drops bytes until restart.
// Reset (synchronous, active high): parser to header phase, counters and
//   limits to zero, sinks absent, output queue empty.
`include "assert_macros.svh"

module avi_movi_chunk_demux_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_stream_byte,
   input  logic [31:0] req_counter_load,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic        rsp_has_byte,
   output logic [7:0]  rsp_payload_byte,
   output logic [31:0] rsp_chunk_length,
   output logic [31:0] rsp_frame_index,
   output logic        rsp_last,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   // ---------------- configuration registers ----------------
   logic [31:0] video_limit_ff;
   logic [31:0] audio_limit_ff;
   logic        video_present_ff;
   logic        audio_present_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         video_limit_ff   <= '0;
         audio_limit_ff   <= '0;
         video_present_ff <= 1'b0;
         audio_present_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            amcd_pkg::CSR_VIDEO_LIMIT:   video_limit_ff   <= csr_data;
            amcd_pkg::CSR_AUDIO_LIMIT:   audio_limit_ff   <= csr_data;
            amcd_pkg::CSR_VIDEO_PRESENT: video_present_ff <= csr_data[0];
            amcd_pkg::CSR_AUDIO_PRESENT: audio_present_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ---------------- parser state ----------------
   amcd_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  pos_ff, pos_in;           // header byte position
   logic [31:0] tag_ff, tag_in;           // FourCC gatherer
   logic [31:0] len_ff, len_in;           // size gatherer / current size
   logic [31:0] left_ff, left_in;         // payload or skip bytes remaining
   logic        pad_ff, pad_in;           // odd-size pad byte still due
   logic [1:0]  ckind_ff, ckind_in;       // kind of chunk in payload
   logic [31:0] vcount_ff, vcount_in;     // video frame counter

   logic                 accept;
   logic                 push;
   logic                 pop;
   logic                 res_valid;
   amcd_pkg::result_type res;

   // per-header decode
   logic [31:0] size;
   logic        is_video;
   logic        is_audio;
   logic        sink_ok;
   logic [31:0] limit;
   logic        pay_last;

   assign accept = req_valid && req_ready;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      tag_in    = tag_ff;
      len_in    = len_ff;
      left_in   = left_ff;
      pad_in    = pad_ff;
      ckind_in  = ckind_ff;
      vcount_in = vcount_ff;
      res_valid = 1'b0;
      res       = '0;

      size     = {req_stream_byte, len_ff[31:8]};
      is_video = (tag_ff == amcd_pkg::TAG_00DB) || (tag_ff == amcd_pkg::TAG_00DC);
      is_audio = (tag_ff == amcd_pkg::TAG_01WB);
      sink_ok  = is_video ? video_present_ff : audio_present_ff;
      limit    = is_video ? video_limit_ff : audio_limit_ff;
      pay_last = (left_ff[31:1] == 31'd0);

      if (req_action == amcd_pkg::ACT_RESTART) begin
         phase_in  = amcd_pkg::PH_HEADER;
         pos_in    = '0;
         tag_in    = '0;
         len_in    = '0;
         left_in   = '0;
         pad_in    = 1'b0;
         vcount_in = req_counter_load;
      end else begin
         case (phase_ff)
            amcd_pkg::PH_HEADER: begin
               if (pos_ff[2] == 1'b0) begin
                  tag_in = {req_stream_byte, tag_ff[31:8]};
               end else begin
                  len_in = size;
               end
               if (pos_ff == amcd_pkg::HDR_LAST_POS) begin
                  pos_in = '0;
                  if (!is_video && !is_audio) begin
                     // other chunk: skip silently
                     left_in  = size;
                     pad_in   = size[0];
                     phase_in = (size == 32'd0) ? amcd_pkg::PH_HEADER
                                                : amcd_pkg::PH_SKIP;
                  end else if (!sink_ok) begin
                     phase_in           = amcd_pkg::PH_HALT;
                     res_valid          = 1'b1;
                     res.kind           = amcd_pkg::KIND_NO_SINK;
                     res.chunk_length   = size;
                     res.last           = 1'b1;
                  end else if (size > limit) begin
                     left_in            = size;
                     pad_in             = size[0];
                     phase_in           = (size == 32'd0) ? amcd_pkg::PH_HEADER
                                                          : amcd_pkg::PH_SKIP;
                     res_valid          = 1'b1;
                     res.kind           = amcd_pkg::KIND_OVERSIZE;
                     res.chunk_length   = size;
                     res.last           = 1'b1;
                  end else begin
                     ckind_in = is_video ? amcd_pkg::KIND_VIDEO : amcd_pkg::KIND_AUDIO;
                     if (size == 32'd0) begin
                        // empty chunk: one marker without a byte
                        res_valid = 1'b1;
                        res.kind  = ckind_in;
                        res.last  = 1'b1;
                        if (is_video) begin
                           res.frame_index = vcount_ff;
                           vcount_in       = vcount_ff + 32'd1;
                        end
                        phase_in = amcd_pkg::PH_HEADER;
                     end else begin
                        left_in  = size;
                        pad_in   = size[0];
                        phase_in = amcd_pkg::PH_PAYLOAD;
                     end
                  end
               end else begin
                  pos_in = pos_ff + 3'd1;
               end
            end
            amcd_pkg::PH_PAYLOAD: begin
               res_valid        = 1'b1;
               res.kind         = ckind_ff;
               res.has_byte     = 1'b1;
               res.payload_byte = req_stream_byte;
               res.chunk_length = len_ff;
               res.frame_index  = (ckind_ff == amcd_pkg::KIND_VIDEO) ? vcount_ff : '0;
               res.last         = pay_last;
               if (left_ff != 32'd0) begin
                  left_in = left_ff - 32'd1;
               end
               if (pay_last) begin
                  if (ckind_ff == amcd_pkg::KIND_VIDEO) begin
                     vcount_in = vcount_ff + 32'd1;
                  end
                  left_in  = '0;
                  phase_in = pad_ff ? amcd_pkg::PH_SKIP : amcd_pkg::PH_HEADER;
                  pos_in   = '0;
               end
            end
            amcd_pkg::PH_SKIP: begin
               if (left_ff != 32'd0) begin
                  left_in = left_ff - 32'd1;
               end else begin
                  pad_in = 1'b0;
               end
               if ((left_in == 32'd0) && !pad_in) begin
                  phase_in = amcd_pkg::PH_HEADER;
                  pos_in   = '0;
               end
            end
            default: ;  // halted: drop bytes until restart
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= amcd_pkg::PH_HEADER;
         pos_ff    <= '0;
         tag_ff    <= '0;
         len_ff    <= '0;
         left_ff   <= '0;
         pad_ff    <= 1'b0;
         ckind_ff  <= amcd_pkg::KIND_VIDEO;
         vcount_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         tag_ff    <= tag_in;
         len_ff    <= len_in;
         left_ff   <= left_in;
         pad_ff    <= pad_in;
         ckind_ff  <= ckind_in;
         vcount_ff <= vcount_in;
      end
   end

   // ---------------- output queue: result register + skid slot ----------------
   amcd_pkg::result_type head_ff;
   amcd_pkg::result_type tail_ff;
   logic [1:0]           count_ff, count_in;

   assign push      = accept && res_valid;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((count_ff == 2'd0) && push) begin
         head_ff <= res;
      end else if ((count_ff == 2'd1) && push && pop) begin
         head_ff <= res;
      end else if ((count_ff == 2'd2) && pop) begin
         head_ff <= tail_ff;
      end
      if ((count_ff == 2'd1) && push && !pop) begin
         tail_ff <= res;
      end
   end

   assign rsp_kind         = head_ff.kind;
   assign rsp_has_byte     = head_ff.has_byte;
   assign rsp_payload_byte = head_ff.payload_byte;
   assign rsp_chunk_length = head_ff.chunk_length;
   assign rsp_frame_index  = head_ff.frame_index;
   assign rsp_last         = head_ff.last;

   // ---------------- assertions ----------------
   `ASSERT_NEVER(a_no_result_when_halted, clock, reset, push && (phase_ff == amcd_pkg::PH_HALT))
   `ASSERT_PROP(a_restart_to_header, clock, reset, (accept && (req_action == amcd_pkg::ACT_RESTART)) |=> ((phase_ff == amcd_pkg::PH_HEADER) && (pos_ff == 3'd0)))
   `ASSERT_NEVER(a_queue_overflow, clock, reset, count_ff == 2'd3)
   `ASSERT_PROP(a_payload_kind, clock, reset, (phase_ff == amcd_pkg::PH_PAYLOAD) |-> ((ckind_ff == amcd_pkg::KIND_VIDEO) || (ckind_ff == amcd_pkg::KIND_AUDIO)))

endmodule

// ===== dv/avi_movi_chunk_demux_top_tb.sv =====
`timescale 1ns / 1ps

module avi_movi_chunk_demux_top_tb;
   import amcd_pkg::*;

   // Tracks the parser state, predicts the result of every accepted item and
   // checks each result item against the oldest prediction.
   class demux_tracker;
      logic [31:0] video_limit;
      logic [31:0] audio_limit;
      logic        video_sink;
      logic        audio_sink;

      phase_type   parse_phase;
      logic [2:0]  hdr_pos;
      logic [31:0] fourcc;
      logic [31:0] chunk_size;
      logic [31:0] bytes_left;
      logic        pad_due;
      logic [1:0]  chunk_kind;
      logic [31:0] frame_count;

      result_type  expected_q[$];
      int          fail_count;

      function new();
         video_limit = '0;
         audio_limit = '0;
         video_sink  = 1'b0;
         audio_sink  = 1'b0;
         parse_phase = PH_HEADER;
         hdr_pos     = '0;
         fourcc      = '0;
         chunk_size  = '0;
         bytes_left  = '0;
         pad_due     = 1'b0;
         chunk_kind  = KIND_VIDEO;
         frame_count = '0;
         fail_count  = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] data);
         case (idx)
            CSR_VIDEO_LIMIT:   video_limit = data;
            CSR_AUDIO_LIMIT:   audio_limit = data;
            CSR_VIDEO_PRESENT: video_sink  = data[0];
            default:           audio_sink  = data[0];
         endcase
      endfunction

      // skip payload plus pad; a zero-size skip goes straight back to header
      function void enter_skip(logic [31:0] size);
         bytes_left  = size;
         pad_due     = size[0];
         parse_phase = (size == 0) ? PH_HEADER : PH_SKIP;
      endfunction

      function void note_item(logic action, logic [7:0] data, logic [31:0] load);
         result_type r;
         bit         produced;
         bit         is_video;
         r        = '0;
         produced = 0;
         if (action == ACT_RESTART) begin
            parse_phase = PH_HEADER;
            hdr_pos     = '0;
            fourcc      = '0;
            chunk_size  = '0;
            bytes_left  = '0;
            pad_due     = 1'b0;
            frame_count = load;
            return;
         end
         case (parse_phase)
            PH_HEADER: begin
               if (hdr_pos < 4) fourcc = {data, fourcc[31:8]};
               else chunk_size = {data, chunk_size[31:8]};
               if (hdr_pos == HDR_LAST_POS) begin
                  hdr_pos  = '0;
                  is_video = (fourcc == TAG_00DB) || (fourcc == TAG_00DC);
                  if (is_video || fourcc == TAG_01WB) begin
                     r.chunk_length = chunk_size;
                     r.last         = 1'b1;
                     produced       = 1;
                     if (!(is_video ? video_sink : audio_sink)) begin
                        // no sink: error and halt until restart
                        r.kind      = KIND_NO_SINK;
                        parse_phase = PH_HALT;
                     end else if (chunk_size > (is_video ? video_limit : audio_limit)) begin
                        r.kind = KIND_OVERSIZE;
                        enter_skip(chunk_size);
                     end else begin
                        chunk_kind = is_video ? KIND_VIDEO : KIND_AUDIO;
                        if (chunk_size == 0) begin
                           // empty chunk: one marker, video still counts a frame
                           r.kind = chunk_kind;
                           if (is_video) begin
                              r.frame_index = frame_count;
                              frame_count   = frame_count + 1;
                           end
                           parse_phase = PH_HEADER;
                        end else begin
                           produced    = 0;
                           bytes_left  = chunk_size;
                           pad_due     = chunk_size[0];
                           parse_phase = PH_PAYLOAD;
                        end
                     end
                  end else begin
                     enter_skip(chunk_size);
                  end
               end else begin
                  hdr_pos = hdr_pos + 3'd1;
               end
            end
            PH_PAYLOAD: begin
               r.kind         = chunk_kind;
               r.has_byte     = 1'b1;
               r.payload_byte = data;
               r.chunk_length = chunk_size;
               r.frame_index  = (chunk_kind == KIND_VIDEO) ? frame_count : '0;
               r.last         = (bytes_left <= 1);
               produced       = 1;
               if (bytes_left != 0) bytes_left = bytes_left - 1;
               if (r.last) begin
                  if (chunk_kind == KIND_VIDEO) frame_count = frame_count + 1;
                  bytes_left  = '0;
                  parse_phase = pad_due ? PH_SKIP : PH_HEADER;
                  hdr_pos     = '0;
               end
            end
            PH_SKIP: begin
               if (bytes_left != 0) bytes_left = bytes_left - 1;
               else pad_due = 1'b0;
               if (bytes_left == 0 && !pad_due) begin
                  parse_phase = PH_HEADER;
                  hdr_pos     = '0;
               end
            end
            default: ;
         endcase
         if (produced) expected_q.push_back(r);
      endfunction

      function void check_result(result_type got);
         result_type want;
         bit         bad;
         if (expected_q.size() == 0) begin
            if (fail_count < 10)
               $display("%0t: unexpected result kind %0d byte %0d/%02h len %0h frame %0h last %0d",
                        $time, got.kind, got.has_byte, got.payload_byte,
                        got.chunk_length, got.frame_index, got.last);
            fail_count++;
            return;
         end
         want = expected_q.pop_front();
         bad  = (got.kind !== want.kind) || (got.has_byte !== want.has_byte) ||
                (got.payload_byte !== want.payload_byte) ||
                (got.chunk_length !== want.chunk_length) ||
                (got.frame_index !== want.frame_index) || (got.last !== want.last);
         if (bad) begin
            if (fail_count < 10) begin
               $display("%0t: result mismatch (expected / actual)", $time);
               $display("   kind %0d / %0d  has_byte %0d / %0d  byte %02h / %02h",
                        want.kind, got.kind, want.has_byte, got.has_byte,
                        want.payload_byte, got.payload_byte);
               $display("   len %08h / %08h  frame %08h / %08h  last %0d / %0d",
                        want.chunk_length, got.chunk_length, want.frame_index,
                        got.frame_index, want.last, got.last);
            end
            fail_count++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function bit halted();
         return parse_phase == PH_HALT;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_action;
   logic [7:0]  req_stream_byte;
   logic [31:0] req_counter_load;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_kind;
   logic        rsp_has_byte;
   logic [7:0]  rsp_payload_byte;
   logic [31:0] rsp_chunk_length;
   logic [31:0] rsp_frame_index;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   demux_tracker tracker;
   int           items_sent;
   bit           req_idle_on;
   bit           rsp_idle_on;

   avi_movi_chunk_demux_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_stream_byte  (req_stream_byte),
      .req_counter_load (req_counter_load),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_chunk_length (rsp_chunk_length),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop far beyond the slowest legal run.
   initial begin
      #10ms;
      $display("Regression FAIL");
      $finish;
   end

   // Result side: ready changes on the falling edge, stalls come in bursts.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Result monitor: sampled on the rising edge, before the block updates.
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.kind         = rsp_kind;
         got.has_byte     = rsp_has_byte;
         got.payload_byte = rsp_payload_byte;
         got.chunk_length = rsp_chunk_length;
         got.frame_index  = rsp_frame_index;
         got.last         = rsp_last;
         tracker.check_result(got);
      end
   end

   // One request item; an optional idle burst goes in front of it. Valid holds
   // until the rising edge that sees ready, and the item is noted there.
   task automatic send_item(input logic action, input logic [7:0] data,
                            input logic [31:0] load);
      int gap;
      gap = 0;
      if (req_idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 18);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= action;
      req_stream_byte  <= data;
      req_counter_load <= load;
      do @(posedge clock); while (!req_ready);
      tracker.note_item(action, data, load);
      items_sent++;
   endtask

   // counter_load is don't-care on bytes; keep it random to toggle its bits
   task automatic send_byte(input logic [7:0] data);
      send_item(ACT_BYTE, data, $urandom());
   endtask

   task automatic send_restart(input logic [31:0] load);
      send_item(ACT_RESTART, 8'($urandom_range(0, 255)), load);
   endtask

   // Header (FourCC then size, both little-endian) followed by body bytes.
   task automatic send_chunk(input logic [31:0] tag, input logic [31:0] size,
                             input int body);
      for (int i = 0; i < 4; i++) send_byte(tag[8*i +: 8]);
      for (int i = 0; i < 4; i++) send_byte(size[8*i +: 8]);
      repeat (body) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [31:0] vlim, input logic [31:0] alim,
                             input logic vsink, input logic asink);
      write_csr(CSR_VIDEO_LIMIT, vlim);
      write_csr(CSR_AUDIO_LIMIT, alim);
      write_csr(CSR_VIDEO_PRESENT, {31'b0, vsink});
      write_csr(CSR_AUDIO_PRESENT, {31'b0, asink});
   endtask

   // Stop sending, wait for every predicted result, then idle on so that an
   // unexpected extra result from the two-slot output queue is still caught.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly well-formed chunks with random content; some noise, truncated
   // chunks with huge sizes, restarts and near-miss FourCCs mixed in.
   task automatic run_random(input int count);
      int          start;
      int          sel;
      logic [31:0] tag;
      logic [31:0] size;
      start = items_sent;
      while (items_sent - start < count) begin
         sel = $urandom_range(0, 99);
         if (tracker.halted() || sel < 4) begin
            if ($urandom_range(0, 3) == 0) send_restart(32'hFFFF_FFFF - $urandom_range(0, 3));
            else send_restart($urandom());
         end else if (sel < 9) begin
            // misaligned header bytes, resync with a restart
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
            send_restart($urandom());
         end else begin
            sel = $urandom_range(0, 99);
            if (sel < 35) tag = TAG_00DC;
            else if (sel < 55) tag = TAG_00DB;
            else if (sel < 85) tag = TAG_01WB;
            else if (sel < 92) tag = $urandom();
            else tag = TAG_00DC ^ (32'h1 << $urandom_range(0, 31));
            if ($urandom_range(0, 9) == 0) begin
               // huge size: cut short by a restart mid-chunk
               size = $urandom();
               send_chunk(tag, size, $urandom_range(0, 12));
               send_restart($urandom());
            end else begin
               size = ($urandom_range(0, 6) == 0) ? 32'd0 : 32'($urandom_range(1, 24));
               send_chunk(tag, size, size + size[0]);
            end
         end
      end
   endtask

   initial begin
      tracker          = new();
      items_sent       = 0;
      req_idle_on      = 1'b1;
      rsp_idle_on      = 1'b1;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_action       <= ACT_BYTE;
      req_stream_byte  <= '0;
      req_counter_load <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= CSR_VIDEO_LIMIT;
      csr_data         <= '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset config: no sinks. Audio header -> missing-sink error, a byte
      // dropped while halted, restart; then an odd-size unknown chunk + pad.
      send_restart(32'hFFFF_FFFF);
      send_chunk(TAG_01WB, 32'd4, 0);
      send_byte(8'hFF);
      send_restart(32'h0);
      send_chunk(32'h4B4E_554A, 32'd1, 2);
      drain_results();

      // Widest limits, both sinks. Zero-size video wraps the frame counter,
      // then a one-byte video chunk with pad and a two-byte audio chunk.
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_restart(32'hFFFF_FFFF);
      send_chunk(TAG_00DB, 32'd0, 0);
      send_chunk(TAG_00DC, 32'd1, 0);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_chunk(TAG_01WB, 32'd2, 0);
      send_byte(8'h00);
      send_byte(8'hFF);
      run_random(300);
      drain_results();

      // Zero limits: every non-empty video or audio chunk is an oversize skip.
      set_config(32'h0, 32'h0, 1'b1, 1'b1);
      send_chunk(TAG_00DC, 32'd3, 4);
      run_random(250);
      drain_results();

      // Small limits near the random sizes; sender pauses midway until all
      // results have arrived.
      set_config($urandom_range(4, 16), $urandom_range(2, 12), 1'b1, 1'b1);
      run_random(175);
      drain_results();
      run_random(175);
      drain_results();

      // One sink missing at a time.
      set_config(32'hFFFF_FFFF, $urandom_range(0, 24), 1'b1, 1'b0);
      run_random(300);
      drain_results();
      set_config($urandom_range(0, 24), 32'hFFFF_FFFF, 1'b0, 1'b1);
      run_random(300);
      drain_results();

      // Final stretch at full rate, no idling on either side.
      set_config(32'd20, 32'hFFFF_FFFF, 1'b1, 1'b1);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_random(300);
      drain_results();

      if (tracker.fail_count == 0 && tracker.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
